@@ design/bnb_pkg.sv @@
// bnb_pkg: shared types, constants and saturating helpers for the batch-norm
// backward unit. No dependencies.
`timescale 1ns / 1ps

package bnb_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 256;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned EPS_W            = 17;
  localparam int unsigned ROWS_W           = 24;

  localparam logic [EPS_W-1:0]  EPS_RESET  = 17'd66;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 24'd1;
  localparam logic [ROWS_W-1:0] ROWS_ONE   = 24'd1;

  localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
  localparam logic [31:0]        R_SAT    = 32'h7FFF_FFFF;
  localparam logic [63:0]        RSQ_NUM  = 64'h0001_0000_0000_0000;  // 2^48

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ACCUM = 2'd1,
    REQ_READ  = 2'd2,
    REQ_GRAD  = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPSILON = 2'd0,
    CFG_ROWS    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         channel;
    logic signed [31:0] gamma_value;
    logic signed [31:0] mean_value;
    logic [30:0]        variance_value;
    logic signed [31:0] out_grad;
    logic signed [31:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dgamma;
    logic signed [31:0] dbeta;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] gamma;
    logic signed [31:0] mean;
    logic [31:0]        inv_std;
  } param_t;

  typedef struct packed {
    logic signed [63:0] sum_dy;
    logic signed [63:0] sum_dyxc;
  } sums_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } sval64_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sval32_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic sval64_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [64:0] s;
    sval64_t     r;
    s     = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sval64_t sat_sub(input logic signed [63:0] a, input logic signed [63:0] b);
    logic [64:0] s;
    sval64_t     r;
    s     = {a[63], a} - {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
    return r;
  endfunction

  function automatic sval32_t sat32(input logic signed [63:0] v);
    sval32_t r;
    r.sat = !((&v[63:31]) || !(|v[63:31]));
    r.val = r.sat ? (v[63] ? S32_MIN : S32_MAX) : v[31:0];
    return r;
  endfunction

endpackage

@@ design/bnb_if.sv @@
// bnb_if: valid/ready channels for request items and result items.
// Depends on bnb_pkg.
`timescale 1ns / 1ps

interface bnb_in_if;
  import bnb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bnb_out_if;
  import bnb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bnb_ram.sv @@
// bnb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bnb_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/bnb_qmul.sv @@
// bnb_qmul: sequential Q16.16 multiply, floor(a*b/2^16) saturated to 64 bits.
// Four 32x32 partial products, one per cycle. Depends on bnb_pkg.
`timescale 1ns / 1ps

module bnb_qmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o,
  output logic               sat_o
);
  import bnb_pkg::*;

  logic [63:0]        ua_q, ub_q, pp_q;
  logic               neg_q;
  logic [1:0]         pp_sh_q;
  logic [127:0]       acc_q;
  logic [2:0]         step_q;
  logic               busy_q, done_q;
  logic signed [63:0] res_q;
  logic               sat_q;

  logic [31:0]        op_a, op_b;
  logic [127:0]       pp_ext;
  logic [63:0]        q0, q1;
  logic               over0, inc, big;
  logic signed [63:0] fin;

  // step bit 1 picks the high half of a, bit 0 the high half of b
  assign op_a = step_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign op_b = step_q[0] ? ub_q[63:32] : ub_q[31:0];

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
      default: pp_ext = {pp_q, 64'd0};
    endcase
  end

  always_comb begin
    q0    = acc_q[79:16];
    over0 = q0[63] && (|q0[62:0]);
    inc   = neg_q && (|acc_q[15:0]) && !over0;
    q1    = q0 + {63'd0, inc};
    big   = (|acc_q[127:80]) || over0 || (neg_q ? (q1[63] && (|q1[62:0])) : q1[63]);
    if (big) begin
      fin = neg_q ? S64_MIN : S64_MAX;
    end else begin
      fin = neg_q ? -$signed(q1) : $signed(q1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= mag64(a_i);
      ub_q  <= mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q <= 3'd3) begin
        pp_q    <= 64'(op_a) * 64'(op_b);
        pp_sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (step_q >= 3'd1 && step_q <= 3'd4) begin
        acc_q <= acc_q + pp_ext;
      end
      if (step_q == 3'd5) begin
        res_q <= fin;
        sat_q <= big;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

@@ design/bnb_div.sv @@
// bnb_div: restoring divider, 64-bit magnitude by 32-bit divisor, one quotient
// bit per cycle, sign applied at the end (truncates toward zero). No dependencies.
`timescale 1ns / 1ps

module bnb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_i,
  input  logic               neg_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0]        num_q;
  logic [31:0]        rem_q, den_q;
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic               busy_q, fix_q, done_q;
  logic signed [63:0] quo_q;

  logic [32:0]        trial, diff;
  logic               ge;

  assign trial = {rem_q, num_q[63]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        fix_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (fix_q) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          if (cnt_q == 6'd63) begin
            fix_q <= 1'b1;
          end
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      if (!fix_q) begin
        rem_q <= ge ? diff[31:0] : trial[31:0];
        num_q <= {num_q[62:0], ge};
      end else begin
        quo_q <= neg_q ? -$signed(num_q) : $signed(num_q);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ design/bnb_isqrt.sv @@
// bnb_isqrt: bit-pair integer square root of a 64-bit value, one result bit
// per cycle. No dependencies.
`timescale 1ns / 1ps

module bnb_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, res_q;
  logic [4:0]  k_q;
  logic        busy_q, done_q;
  logic [63:0] bitv, t;

  assign bitv = 64'd1 << {k_q, 1'b0};
  assign t    = res_q + bitv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= 5'd31;
      end else if (busy_q) begin
        if (k_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        k_q <= k_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (x_q >= t) begin
        x_q   <= x_q - t;
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

@@ design/batch_norm_backward_unit.sv @@
// batch_norm_backward_unit: per-channel batch-norm backward, Q16.16, one item at a time.
// Steps: load divides, takes an rsqrt and writes the tables (zero variance plus epsilon
// skips to the write); accumulate one multiply and a sum write; readout one multiply;
// input gradient two divides and five multiplies. Readout and input gradient results wait
// while the output register is full. Items are taken only in idle; the units are shared.
// Reset: async active low; clears control, config to defaults. Tables are not cleared.
`timescale 1ns / 1ps

module batch_norm_backward_unit #(
  parameter int unsigned MAX_CHANNELS = bnb_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bnb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bnb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bnb_in_if.sink                          req_i,
  bnb_out_if.source                       rsp_o
);
  import bnb_pkg::*;

  localparam int unsigned ChAddrW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // one-hot sequencer
  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_LD_DIV  = 19'h00002,
    S_LD_SQRT = 19'h00004,
    S_LD_WR   = 19'h00008,
    S_RD      = 19'h00010,
    S_FETCH   = 19'h00020,
    S_AC_MUL  = 19'h00040,
    S_AC_WR   = 19'h00080,
    S_RO_MUL  = 19'h00100,
    S_GR_DIV0 = 19'h00200,
    S_GR_DIV1 = 19'h00400,
    S_GR_RR   = 19'h00800,
    S_GR_C2   = 19'h01000,
    S_GR_T    = 19'h02000,
    S_GR_SUB0 = 19'h04000,
    S_GR_SUB1 = 19'h08000,
    S_GR_C1   = 19'h10000,
    S_GR_IG   = 19'h20000,
    S_PUSH    = 19'h40000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [EPS_W-1:0]  eps_q;
  logic [ROWS_W-1:0] rows_q, n_eff;

  // item and working registers
  in_item_t           item_q;
  logic [31:0]        v_q, v_in;
  logic signed [63:0] quo_q;
  logic signed [31:0] gam_q;
  logic [31:0]        r_q;
  logic signed [63:0] sdy_q, sdyxc_q;
  logic signed [32:0] xc_q;
  logic signed [63:0] prod_q, mdy_q, mdyxc_q, rr_q, c2_q, t_q, d_q, c1_q;
  logic               sat_q;
  out_item_t          rb_q, out_q;
  logic               out_valid_q;
  logic               launch_q;

  logic in_xfer, in_range, push;

  // memories: per-channel parameters and per-channel sums
  logic [ChAddrW-1:0] ch_addr;
  param_t             prm_wdata, prm_rdata;
  sums_t              sum_wdata, sum_rdata;
  logic               prm_we, sum_we;

  // shared arithmetic units
  logic               need_mul, need_div, need_sqrt;
  logic               mul_go, div_go, sqrt_go;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic               mul_done, mul_sat;
  logic [63:0]        div_num;
  logic               div_neg;
  logic [31:0]        div_den;
  logic signed [63:0] div_quo;
  logic               div_done;
  logic [31:0]        sqrt_root;
  logic               sqrt_done;
  logic               unit_done;

  sval64_t add_dy, add_xc, sub0, sub1;
  sval32_t bg, gg, ig;

  assign in_range = 32'(req_i.data.channel) < MAX_CHANNELS;
  assign in_xfer  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign v_in  = {1'b0, req_i.data.variance_value} + 32'(eps_q);
  assign n_eff = (rows_q == '0) ? ROWS_ONE : rows_q;
  assign ch_addr = ChAddrW'(item_q.channel);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q  <= EPS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EPSILON: eps_q  <= cfg_data_i[EPS_W-1:0];
        CFG_ROWS:    rows_q <= cfg_data_i[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  bnb_ram #(.Width($bits(param_t)), .Depth(MAX_CHANNELS)) u_prm_ram (
    .clk_i   (clk_i),
    .we_i    (prm_we),
    .waddr_i (ch_addr),
    .wdata_i (prm_wdata),
    .raddr_i (ch_addr),
    .rdata_o (prm_rdata)
  );

  bnb_ram #(.Width($bits(sums_t)), .Depth(MAX_CHANNELS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (ch_addr),
    .wdata_i (sum_wdata),
    .raddr_i (ch_addr),
    .rdata_o (sum_rdata)
  );

  bnb_qmul u_qmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  bnb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .neg_i   (div_neg),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  bnb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_go),
    .x_i     (quo_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // operand selection per step
  always_comb begin
    need_mul  = 1'b0;
    need_div  = 1'b0;
    need_sqrt = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_neg   = 1'b0;
    div_den   = '0;
    case (state_q)
      S_LD_DIV: begin
        need_div = 1'b1;
        div_num  = RSQ_NUM;
        div_den  = v_q;
      end
      S_LD_SQRT: need_sqrt = 1'b1;
      S_AC_MUL: begin
        need_mul = 1'b1;
        mul_a    = 64'(item_q.out_grad);
        mul_b    = 64'(xc_q);
      end
      S_RO_MUL: begin
        need_mul = 1'b1;
        mul_a    = {32'd0, r_q};
        mul_b    = sdyxc_q;
      end
      S_GR_DIV0: begin
        need_div = 1'b1;
        div_num  = mag64(sdy_q);
        div_neg  = sdy_q[63];
        div_den  = 32'(n_eff);
      end
      S_GR_DIV1: begin
        need_div = 1'b1;
        div_num  = mag64(sdyxc_q);
        div_neg  = sdyxc_q[63];
        div_den  = 32'(n_eff);
      end
      S_GR_RR: begin
        need_mul = 1'b1;
        mul_a    = {32'd0, r_q};
        mul_b    = {32'd0, r_q};
      end
      S_GR_C2: begin
        need_mul = 1'b1;
        mul_a    = rr_q;
        mul_b    = mdyxc_q;
      end
      S_GR_T: begin
        need_mul = 1'b1;
        mul_a    = 64'(xc_q);
        mul_b    = c2_q;
      end
      S_GR_C1: begin
        need_mul = 1'b1;
        mul_a    = 64'(gam_q);
        mul_b    = {32'd0, r_q};
      end
      S_GR_IG: begin
        need_mul = 1'b1;
        mul_a    = c1_q;
        mul_b    = d_q;
      end
      default: ;
    endcase
  end

  // each unit gets one start pulse per step; launch_q remembers it is running
  assign mul_go    = need_mul && !launch_q;
  assign div_go    = need_div && !launch_q;
  assign sqrt_go   = need_sqrt && !launch_q;
  assign unit_done = mul_done || div_done || sqrt_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else if (unit_done) begin
      launch_q <= 1'b0;
    end else if (mul_go || div_go || sqrt_go) begin
      launch_q <= 1'b1;
    end
  end

  // saturating arithmetic between unit steps
  assign add_dy = sat_add(sdy_q, 64'(item_q.out_grad));
  assign add_xc = sat_add(sdyxc_q, prod_q);
  assign sub0   = sat_sub(64'(item_q.out_grad), mdy_q);
  assign sub1   = sat_sub(d_q, t_q);
  assign bg     = sat32(sdy_q);
  assign gg     = sat32(mul_res);
  assign ig     = sat32(mul_res);

  // table writes
  assign prm_we    = (state_q == S_LD_WR);
  assign sum_we    = (state_q == S_LD_WR) || (state_q == S_AC_WR);
  assign prm_wdata = '{gamma: item_q.gamma_value, mean: item_q.mean_value, inv_std: r_q};
  always_comb begin
    if (state_q == S_AC_WR) begin
      sum_wdata = '{sum_dy: add_dy.val, sum_dyxc: add_xc.val};
    end else begin
      sum_wdata = '0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    push    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid && in_range) begin
          if (req_i.data.req_type == REQ_LOAD) begin
            state_d = (v_in == '0) ? S_LD_WR : S_LD_DIV;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_LD_DIV:  if (div_done) state_d = S_LD_SQRT;
      S_LD_SQRT: if (sqrt_done) state_d = S_LD_WR;
      S_LD_WR:   state_d = S_IDLE;
      S_RD:      state_d = S_FETCH;
      S_FETCH: begin
        case (req_e'(item_q.req_type))
          REQ_ACCUM: state_d = S_AC_MUL;
          REQ_READ:  state_d = S_RO_MUL;
          default:   state_d = S_GR_DIV0;
        endcase
      end
      S_AC_MUL:  if (mul_done) state_d = S_AC_WR;
      S_AC_WR:   state_d = S_IDLE;
      S_RO_MUL:  if (mul_done) state_d = S_PUSH;
      S_GR_DIV0: if (div_done) state_d = S_GR_DIV1;
      S_GR_DIV1: if (div_done) state_d = S_GR_RR;
      S_GR_RR:   if (mul_done) state_d = S_GR_C2;
      S_GR_C2:   if (mul_done) state_d = S_GR_T;
      S_GR_T:    if (mul_done) state_d = S_GR_SUB0;
      S_GR_SUB0: state_d = S_GR_SUB1;
      S_GR_SUB1: state_d = S_GR_C1;
      S_GR_C1:   if (mul_done) state_d = S_GR_IG;
      S_GR_IG:   if (mul_done) state_d = S_PUSH;
      S_PUSH: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || rsp_o.ready) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= req_i.data;
      v_q    <= v_in;
      r_q    <= R_SAT;   // kept when variance plus epsilon is zero
      sat_q  <= 1'b0;
    end
    if (push) begin
      out_q <= rb_q;
    end
    case (state_q)
      S_LD_DIV:  if (div_done) quo_q <= div_quo;
      S_LD_SQRT: if (sqrt_done) r_q <= sqrt_root;
      S_FETCH: begin
        gam_q   <= prm_rdata.gamma;
        r_q     <= prm_rdata.inv_std;
        sdy_q   <= sum_rdata.sum_dy;
        sdyxc_q <= sum_rdata.sum_dyxc;
        xc_q    <= 33'(item_q.in_value) - 33'(prm_rdata.mean);
      end
      S_AC_MUL:  if (mul_done) prod_q <= mul_res;
      S_RO_MUL: begin
        if (mul_done) begin
          rb_q <= '{dx: '0, dgamma: gg.val, dbeta: bg.val,
                    saturated: sat_q | mul_sat | gg.sat | bg.sat};
        end
      end
      S_GR_DIV0: if (div_done) mdy_q <= div_quo;
      S_GR_DIV1: if (div_done) mdyxc_q <= div_quo;
      S_GR_RR: begin
        if (mul_done) begin
          rr_q  <= mul_res;
          sat_q <= sat_q | mul_sat;
        end
      end
      S_GR_C2: begin
        if (mul_done) begin
          c2_q  <= mul_res;
          sat_q <= sat_q | mul_sat;
        end
      end
      S_GR_T: begin
        if (mul_done) begin
          t_q   <= mul_res;
          sat_q <= sat_q | mul_sat;
        end
      end
      S_GR_SUB0: begin
        d_q   <= sub0.val;
        sat_q <= sat_q | sub0.sat;
      end
      S_GR_SUB1: begin
        d_q   <= sub1.val;
        sat_q <= sat_q | sub1.sat;
      end
      S_GR_C1: begin
        if (mul_done) begin
          c1_q  <= mul_res;
          sat_q <= sat_q | mul_sat;
        end
      end
      S_GR_IG: begin
        if (mul_done) begin
          rb_q <= '{dx: ig.val, dgamma: '0, dbeta: '0,
                    saturated: sat_q | mul_sat | ig.sat};
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // a unit only finishes work that the sequencer started
  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> launch_q)
    else $error("arith unit finished without a launch");

  // only one shared unit finishes at a time
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_done, div_done, sqrt_done}))
    else $error("more than one arith unit finished at once");

  // a result appears only from the push step
  a_rsp_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == S_PUSH))
    else $error("result valid raised outside push");

  // no table write while an arith unit is running
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prm_we || sum_we) |-> !launch_q)
    else $error("table write while a unit is busy");

endmodule

@@ dv/batch_norm_backward_unit_tb.sv @@
// batch_norm_backward_unit_tb: self-checking testbench for the batch-norm backward unit.
// Depends on bnb_pkg, bnb_if and batch_norm_backward_unit.
// Drives random and directed request streams, predicts every result and checks it.
`timescale 1ns / 1ps

module batch_norm_backward_unit_tb;
  import bnb_pkg::*;

  localparam int NUM_CH     = 256;
  localparam int DRAIN_WAIT = 400;    // longer than the slowest request
  localparam int HOLD_OFF   = 500;    // long receiver stall in the pressure test
  localparam int STALL_MAX  = 8000;   // cycles without a transfer before we give up

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  bnb_in_if  req_if ();
  bnb_out_if rsp_if ();

  batch_norm_backward_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the unit: config plus per-channel tables.
  logic [EPS_W-1:0]   eps_cfg  = EPS_RESET;
  logic [ROWS_W-1:0]  rows_cfg = ROWS_RESET;
  logic signed [63:0] gamma_tab [NUM_CH];
  logic signed [63:0] mean_tab [NUM_CH];
  logic signed [63:0] rstd_tab [NUM_CH];
  logic signed [63:0] dy_sum_tab [NUM_CH];
  logic signed [63:0] dyxc_sum_tab [NUM_CH];
  bit                 loaded [NUM_CH];
  int                 live_ch [$];

  out_item_t pending_grads [$];
  bit        sat_seen;
  int        errors = 0;
  int        stall_cycles = 0;
  bit        no_idle = 1'b0;     // both sides run flat out while set
  bit        hold_req = 1'b0;    // asks the receiver for one long stall

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the unit
  // ---------------------------------------------------------------------------
  // floor(a*b / 2^16), clipped to signed 64 bits
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p  = (wa * wb) >>> 16;
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) begin
      sat_seen = 1'b1;
      return S64_MAX;
    end
    if (p < -128'sh8000_0000_0000_0000) begin
      sat_seen = 1'b1;
      return S64_MIN;
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_seen = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      sat_seen = 1'b1;
      return S32_MAX;
    end
    if (v < -64'sh8000_0000) begin
      sat_seen = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Update the shadow tables for one accepted request; queue its result if any.
  task automatic predict_gradient(input in_item_t it);
    logic [63:0]        v;
    logic signed [63:0] dy, xc, n, r, mdy, mdyxc, rr, c2, d, c1, keep;
    out_item_t          res;
    int                 ch;
    ch  = it.channel;
    dy  = it.out_grad;
    n   = (rows_cfg == 0) ? 64'sd1 : {40'd0, rows_cfg};
    res = '0;
    sat_seen = 1'b0;
    case (req_e'(it.req_type))
      REQ_LOAD: begin
        v = {33'd0, it.variance_value} + {47'd0, eps_cfg};
        gamma_tab[ch]    = it.gamma_value;
        mean_tab[ch]     = it.mean_value;
        rstd_tab[ch]     = (v == 0) ? 64'h7FFF_FFFF : isqrt(RSQ_NUM / v);
        dy_sum_tab[ch]   = 0;
        dyxc_sum_tab[ch] = 0;
        if (!loaded[ch]) begin
          loaded[ch] = 1'b1;
          live_ch.push_back(ch);
        end
      end
      REQ_ACCUM: begin
        // sums clip silently; the flag is not part of any result
        xc               = 64'(it.in_value) - mean_tab[ch];
        dy_sum_tab[ch]   = add_clip(dy_sum_tab[ch], dy);
        keep             = qmul(dy, xc);
        dyxc_sum_tab[ch] = add_clip(dyxc_sum_tab[ch], keep);
      end
      REQ_READ: begin
        res.dbeta     = clip32(dy_sum_tab[ch]);
        res.dgamma    = clip32(qmul(rstd_tab[ch], dyxc_sum_tab[ch]));
        res.saturated = sat_seen;
        pending_grads.push_back(res);
      end
      default: begin
        xc    = 64'(it.in_value) - mean_tab[ch];
        r     = rstd_tab[ch];
        mdy   = dy_sum_tab[ch] / n;
        mdyxc = dyxc_sum_tab[ch] / n;
        rr    = qmul(r, r);
        c2    = qmul(rr, mdyxc);
        d     = sub_clip(dy, mdy);
        d     = sub_clip(d, qmul(xc, c2));
        c1    = qmul(gamma_tab[ch], r);
        res.dx        = clip32(qmul(c1, d));
        res.saturated = sat_seen;
        pending_grads.push_back(res);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side: one transfer per call, prediction at acceptance
  // ---------------------------------------------------------------------------
  task automatic send_request(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk_i); while (!req_if.ready);
    predict_gradient(it);
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_grads.size() != 0) @(negedge clk_i);
    // loads give no result and may still be running
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_EPSILON) eps_cfg = val[EPS_W-1:0];
    else rows_cfg = val[ROWS_W-1:0];
  endtask

  // Q16.16 operand with a bias toward the ends of the range
  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 32'sd0;
      3: return $signed(32'($urandom_range(0, 32'h3_0000))) - 32'sh1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(input req_e kind, input int ch);
    in_item_t it;
    it.req_type       = kind;
    it.channel        = ch[7:0];
    it.gamma_value    = pick32();
    it.mean_value     = pick32();
    it.variance_value = ($urandom_range(0, 5) == 0) ? 31'd0 : 31'($urandom);
    it.out_grad       = pick32();
    it.in_value       = pick32();
    return it;
  endfunction

  // Mostly well-formed traffic: loads open channels, then sums, reads and gradients.
  task automatic run_traffic(input int count, input int grad_bias);
    int        k, ch;
    req_e      kind;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (live_ch.size() == 0 || k < 8) begin
        kind = REQ_LOAD;
        ch   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      end else begin
        kind = (k < 55) ? REQ_ACCUM : (k < 55 + grad_bias) ? REQ_GRAD : REQ_READ;
        ch   = live_ch[$urandom_range(0, live_ch.size() - 1)];
      end
      send_request(make_item(kind, ch));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_OFF;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  always @(posedge clk_i) begin
    out_item_t want, got;
    if (rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_grads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending_grads.pop_front();
        if (got.dx !== want.dx) begin
          errors++;
          $display("%0t: dx exp %h got %h", $time, want.dx, got.dx);
        end
        if (got.dgamma !== want.dgamma) begin
          errors++;
          $display("%0t: dgamma exp %h got %h", $time, want.dgamma, got.dgamma);
        end
        if (got.dbeta !== want.dbeta) begin
          errors++;
          $display("%0t: dbeta exp %h got %h", $time, want.dbeta, got.dbeta);
        end
        if (got.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated exp %b got %b", $time, want.saturated, got.saturated);
        end
      end
    end
  end

  // Watchdog: a run with no transfer on either side for too long has hung.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extremes of every field, every request kind, zero variance, min/max channel.
  task automatic test_directed();
    in_item_t it;
    no_idle = 1'b1;
    it = make_item(REQ_LOAD, 0);
    it.gamma_value = S32_MAX; it.mean_value = S32_MIN; it.variance_value = '0;
    send_request(it);
    it = make_item(REQ_LOAD, 255);
    it.gamma_value = S32_MIN; it.mean_value = S32_MAX; it.variance_value = '1;
    send_request(it);
    for (int i = 0; i < 4; i++) begin
      it = make_item(REQ_ACCUM, (i < 2) ? 0 : 255);
      it.out_grad = i[0] ? S32_MIN : S32_MAX;
      it.in_value = i[0] ? S32_MAX : S32_MIN;
      send_request(it);
    end
    send_request(make_item(REQ_READ, 0));
    send_request(make_item(REQ_READ, 255));
    for (int i = 0; i < 4; i++) begin
      it = make_item(REQ_GRAD, i[0] ? 255 : 0);
      it.out_grad = i[1] ? S32_MIN : S32_MAX;
      it.in_value = i[0] ? S32_MIN : S32_MAX;
      send_request(it);
    end
    // small, well-conditioned channel
    it = make_item(REQ_LOAD, 1);
    it.gamma_value = 32'sh1_0000; it.mean_value = 32'sh0_8000; it.variance_value = 31'h1_0000;
    send_request(it);
    for (int i = 0; i < 3; i++) begin
      it = make_item(REQ_ACCUM, 1);
      it.out_grad = 32'sh1_0000 * (i + 1); it.in_value = 32'sh2_0000 - i * 32'sh1_0000;
      send_request(it);
    end
    send_request(make_item(REQ_READ, 1));
    send_request(make_item(REQ_GRAD, 1));
    no_idle = 1'b0;
    go_idle();
  endtask

  // Config settings from zero to large values, traffic after each.
  task automatic test_config_sweep();
    write_reg(CFG_EPSILON, 24'd0);      // zero variance gives r at its limit
    write_reg(CFG_ROWS, 24'd0);         // N of zero behaves as one
    run_traffic(200, 20);
    go_idle();
    write_reg(CFG_EPSILON, 24'd65536);
    write_reg(CFG_ROWS, 24'd16777215);
    run_traffic(200, 20);
    go_idle();
    write_reg(CFG_EPSILON, 24'd1);
    write_reg(CFG_ROWS, 24'd1);
    no_idle = 1'b1;
    run_traffic(150, 20);
    no_idle = 1'b0;
    go_idle();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_EPSILON, 24'($urandom_range(0, 65536)));
      write_reg(CFG_ROWS, 24'($urandom_range(1, 64)));
      run_traffic(170, 20);
      go_idle();
    end
  endtask

  // Receiver stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    write_reg(CFG_ROWS, 24'd8);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    run_traffic(200, 35);
    no_idle  = 1'b0;
    go_idle();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ batch_norm_backward_unit.f @@
design/bnb_pkg.sv
design/bnb_if.sv
design/bnb_ram.sv
design/bnb_qmul.sv
design/bnb_div.sv
design/bnb_isqrt.sv
design/batch_norm_backward_unit.sv
dv/batch_norm_backward_unit_tb.sv
